[rtl/per_cache_buffer_free_list_pool_unit_macros.svh]
// Assertion macros used by the pool control RTL.
`ifndef PER_CACHE_BUFFER_FREE_LIST_POOL_UNIT_MACROS_SVH
`define PER_CACHE_BUFFER_FREE_LIST_POOL_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define PCBFL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PCBFL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PCBFL_ASSERT_IMP(lbl, ante, cons, msg)
`define PCBFL_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/pcbfl_pkg.sv]
`default_nettype none
package pcbfl_pkg;
	localparam int CACHE_SLOTS_DEF = 16;
	localparam int NUM_BUFFERS_DEF = 1024;

	localparam int SEL_W      = 4;
	localparam int BUF_IO_W   = 10;
	localparam int CNT_W      = 11;
	localparam int NCACHE_W   = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_CACHES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFERS = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic                init;
		logic [NCACHE_W-1:0] ncache;
		logic [CNT_W-1:0]    limit;
		logic [CNT_W-1:0]    nbuf;
	} cfg_t;
endpackage
`default_nettype wire

[rtl/pcbfl_ram.sv]
`default_nettype none
module pcbfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[rtl/pcbfl_ctrl.sv]
`default_nettype none
`include "per_cache_buffer_free_list_pool_unit_macros.svh"
module pcbfl_ctrl #(
	parameter int CACHE_SLOTS = pcbfl_pkg::CACHE_SLOTS_DEF,
	parameter int NUM_BUFFERS = pcbfl_pkg::NUM_BUFFERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcbfl_pkg::cfg_t               cfg,
	output logic                          idle,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic                          cache_valid,
	input  logic [pcbfl_pkg::SEL_W-1:0]   cache_sel,
	input  logic [pcbfl_pkg::BUF_IO_W-1:0] buffer_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pcbfl_pkg::BUF_IO_W-1:0] buffer_out,
	output logic                          granted,
	output logic                          from_cache,
	output logic [pcbfl_pkg::CNT_W-1:0]   shared_free
);
	import pcbfl_pkg::*;

	localparam int CS_W   = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
	localparam int BUF_W  = $clog2(NUM_BUFFERS);
	localparam int LINK_W = BUF_W + 1;
	localparam int TAB_W  = CNT_W + BUF_W + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TAB  = 2'd1;
	localparam logic [1:0] ST_LINK = 2'd2;

	logic [1:0] state_q;

	logic             free_s1, use_s1, inr_s1, tvld_s1;
	logic [CS_W-1:0]  csel_s1;
	logic [BUF_IO_W-1:0] buf_s1;

	logic [BUF_W-1:0] hd_s2;
	logic [CNT_W-1:0] cnt_s2;
	logic             ok_s2, popc_s2, pops_s2, fresh_s2, pushc_s2;

	logic [CACHE_SLOTS-1:0] cvld_q;
	logic [BUF_W-1:0]      shead_q;
	logic                  sok_q;
	logic [CNT_W-1:0]      stotal_q;
	logic [CNT_W-1:0]      nused_q;

	logic                ov_q, gr_q, fc_q;
	logic [BUF_IO_W-1:0] bo_q;
	logic [CNT_W-1:0]    sf_q;

	logic              accept, use_in, fire;
	logic [CS_W-1:0]   raddr_in;
	logic              tab_we, link_we, link_re;
	logic [TAB_W-1:0]  tab_rdata, tab_wdata;
	logic [LINK_W-1:0] link_rdata, link_wdata;
	logic [BUF_W-1:0]  link_raddr, link_waddr;

	logic [CNT_W-1:0] t_cnt;
	logic [BUF_W-1:0] t_hd;
	logic             t_ok, popc, pops, fresh, pushc;

	logic             l_end;
	logic [BUF_W-1:0] l_idx;
	logic [CNT_W-1:0] cnt_dec, cnt_inc, stotal_nx;
	logic             gr_nx;
	logic [BUF_W-1:0] res_nx;

	assign idle     = (state_q == ST_IDLE);
	assign in_ready = idle && !cfg.init;
	assign accept   = in_valid && in_ready;
	assign raddr_in = CS_W'(cache_sel);
	assign use_in   = cache_valid && ({1'b0, cache_sel} < cfg.ncache)
		&& (32'(cache_sel) < CACHE_SLOTS);

	// table read: stage 1
	assign t_cnt = tvld_s1 ? tab_rdata[TAB_W-1 -: CNT_W] : '0;
	assign t_hd  = tab_rdata[BUF_W:1];
	assign t_ok  = tvld_s1 && tab_rdata[0];
	assign popc  = use_s1 && t_ok && (t_cnt != '0);
	assign pops  = !popc && sok_q;
	assign fresh = !popc && !sok_q && (nused_q < cfg.nbuf);
	assign pushc = use_s1 && (t_cnt < cfg.limit);

	assign link_re    = (state_q == ST_TAB) && !free_s1 && (popc || pops);
	assign link_raddr = popc ? t_hd : shead_q;

	// link read: stage 2
	assign fire    = (state_q == ST_LINK) && (!ov_q || out_ready);
	assign l_end   = link_rdata[BUF_W];
	assign l_idx   = link_rdata[BUF_W-1:0];
	assign cnt_dec = cnt_s2 - 1'b1;
	assign cnt_inc = cnt_s2 + 1'b1;

	assign tab_we    = fire && ((!free_s1 && popc_s2) || (free_s1 && inr_s1 && pushc_s2));
	assign tab_wdata = free_s1 ? {cnt_inc, BUF_W'(buf_s1), 1'b1}
		: {cnt_dec, l_idx, !l_end && (cnt_dec != '0)};

	assign link_we    = fire && free_s1 && inr_s1;
	assign link_waddr = BUF_W'(buf_s1);
	always_comb begin
		if (pushc_s2) begin
			link_wdata = ok_s2 ? {1'b0, hd_s2} : {1'b1, {BUF_W{1'b0}}};
		end else begin
			link_wdata = sok_q ? {1'b0, shead_q} : {1'b1, {BUF_W{1'b0}}};
		end
	end

	always_comb begin
		gr_nx     = 1'b0;
		res_nx    = '0;
		stotal_nx = stotal_q;
		if (!free_s1) begin
			gr_nx = popc_s2 || pops_s2 || fresh_s2;
			priority if (popc_s2) begin
				res_nx = hd_s2;
			end else if (pops_s2) begin
				res_nx = shead_q;
			end else if (fresh_s2) begin
				res_nx = BUF_W'(nused_q);
			end
			if (gr_nx && !popc_s2 && (stotal_q != '0)) begin
				stotal_nx = stotal_q - 1'b1;
			end
		end else if (inr_s1 && !pushc_s2 && (stotal_q < cfg.nbuf)) begin
			stotal_nx = stotal_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cvld_q   <= '0;
			shead_q  <= '0;
			sok_q    <= 1'b0;
			stotal_q <= '0;
			nused_q  <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (fire || (out_ready && ov_q)) begin
				ov_q <= fire;
			end
			if (cfg.init) begin
				cvld_q   <= '0;
				sok_q    <= 1'b0;
				stotal_q <= cfg.nbuf;
				nused_q  <= '0;
			end else if (fire) begin
				stotal_q <= stotal_nx;
				if (tab_we) begin
					cvld_q[csel_s1] <= 1'b1;
				end
				if (!free_s1 && pops_s2) begin
					shead_q <= l_idx;
					sok_q   <= !l_end;
				end
				if (!free_s1 && fresh_s2) begin
					nused_q <= nused_q + 1'b1;
				end
				if (link_we && !pushc_s2) begin
					shead_q <= link_waddr;
					sok_q   <= 1'b1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_TAB;
					end
				end
				ST_TAB: begin
					state_q <= ST_LINK;
				end
				ST_LINK: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			free_s1 <= (op == OP_FREE);
			use_s1  <= use_in;
			inr_s1  <= ({1'b0, buffer_in} < cfg.nbuf);
			tvld_s1 <= use_in && cvld_q[raddr_in];
			csel_s1 <= raddr_in;
			buf_s1  <= buffer_in;
		end
		if (state_q == ST_TAB) begin
			hd_s2    <= t_hd;
			cnt_s2   <= t_cnt;
			ok_s2    <= t_ok;
			popc_s2  <= popc;
			pops_s2  <= pops;
			fresh_s2 <= fresh;
			pushc_s2 <= pushc;
		end
		if (fire) begin
			bo_q <= BUF_IO_W'(res_nx);
			gr_q <= gr_nx;
			fc_q <= free_s1 ? (inr_s1 && pushc_s2) : popc_s2;
			sf_q <= stotal_nx;
		end
	end

	pcbfl_ram #(.WIDTH(TAB_W), .DEPTH(CACHE_SLOTS)) u_tab (
		.clk   (clk),
		.we    (tab_we),
		.waddr (csel_s1),
		.wdata (tab_wdata),
		.re    (accept),
		.raddr (raddr_in),
		.rdata (tab_rdata)
	);

	pcbfl_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BUFFERS)) u_link (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	assign out_valid   = ov_q;
	assign buffer_out  = bo_q;
	assign granted     = gr_q;
	assign from_cache  = fc_q;
	assign shared_free = sf_q;

	`PCBFL_ASSERT_IMP(a_total_cap, !cfg.init, stotal_q <= cfg.nbuf, "shared total above pool size")
	`PCBFL_ASSERT_IMP(a_fresh_cap, !cfg.init, nused_q <= cfg.nbuf, "fresh index past pool size")
	`PCBFL_ASSERT_NXT(a_stall_hold, state_q == ST_LINK && ov_q && !out_ready, state_q == ST_LINK, "update ran into a full output")
	`PCBFL_ASSERT_IMP(a_nogrant_zero, ov_q && !gr_q, bo_q == '0, "nonzero buffer without grant")
endmodule
`default_nettype wire

[rtl/per_cache_buffer_free_list_pool_unit.sv]
// Buffer pool with per-cache LIFO free lists.
// Request channel (in_valid/in_ready): op allocates (0) or frees (1) a buffer,
// optionally through the cache named by cache_valid/cache_sel.
// Result channel (out_valid/out_ready): one result per request with the
// allocated index, grant and cache flags, and the shared pool count.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): 0 caches in use,
// 1 cache list limit, 2 buffers in use. A write reinitializes all lists and
// counts in the following cycle; other indexes are accepted and dropped.
// The result is registered after the cache table read, the link memory read and
// the update. A new request is taken only after the previous one leaves the update,
// set by the chain of table read then link read on one list.
// The output register lets the next request enter while a result waits; a
// stalled receiver holds the update stage until the result register frees.
// Reset: registers return to 16/32/1024 and the first cycle after reset
// initializes the pool; requests are taken from the next cycle on.
`default_nettype none
module per_cache_buffer_free_list_pool_unit #(
	parameter int CACHE_SLOTS = pcbfl_pkg::CACHE_SLOTS_DEF,
	parameter int NUM_BUFFERS = pcbfl_pkg::NUM_BUFFERS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pcbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcbfl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             op,
	input  logic                             cache_valid,
	input  logic [pcbfl_pkg::SEL_W-1:0]      cache_sel,
	input  logic [pcbfl_pkg::BUF_IO_W-1:0]   buffer_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pcbfl_pkg::BUF_IO_W-1:0]   buffer_out,
	output logic                             granted,
	output logic                             from_cache,
	output logic [pcbfl_pkg::CNT_W-1:0]      shared_free
);
	import pcbfl_pkg::*;

	logic [NCACHE_W-1:0] caches_q;
	logic [CNT_W-1:0]    limit_q;
	logic [CNT_W-1:0]    buffers_q;
	logic                init_q;
	logic                ctrl_idle;
	cfg_t                cfg;

	assign cfg_ready = ctrl_idle && !init_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caches_q  <= NCACHE_W'(16);
			limit_q   <= CNT_W'(32);
			buffers_q <= CNT_W'(1024);
			init_q    <= 1'b1;
		end else begin
			init_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_CACHES: begin
						caches_q <= cfg_data[NCACHE_W-1:0];
						init_q   <= 1'b1;
					end
					REG_LIMIT: begin
						limit_q <= cfg_data;
						init_q  <= 1'b1;
					end
					REG_BUFFERS: begin
						buffers_q <= cfg_data;
						init_q    <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		cfg.init   = init_q;
		cfg.limit  = limit_q;
		cfg.ncache = (32'(caches_q) > CACHE_SLOTS) ? NCACHE_W'(CACHE_SLOTS) : caches_q;
		cfg.nbuf   = (32'(buffers_q) > NUM_BUFFERS) ? CNT_W'(NUM_BUFFERS) : buffers_q;
	end

	pcbfl_ctrl #(.CACHE_SLOTS(CACHE_SLOTS), .NUM_BUFFERS(NUM_BUFFERS)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.idle        (ctrl_idle),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.cache_valid (cache_valid),
		.cache_sel   (cache_sel),
		.buffer_in   (buffer_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.buffer_out  (buffer_out),
		.granted     (granted),
		.from_cache  (from_cache),
		.shared_free (shared_free)
	);
endmodule
`default_nettype wire

[verif/tb.sv]
`default_nettype none
module tb;
	import pcbfl_pkg::*;

	localparam int RUN_LIMIT = 400000;
	localparam int PHASE_ITEMS = 175;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic                op;
		logic                named;
		logic [SEL_W-1:0]    sel;
		logic [BUF_IO_W-1:0] buf_idx;
	} pool_req_t;

	typedef struct packed {
		logic [BUF_IO_W-1:0] buf_idx;
		logic                gnt;
		logic                cached;
		logic [CNT_W-1:0]    pool_free;
	} pool_reply_t;

	typedef struct packed {
		logic                last;
		logic [BUF_IO_W-1:0] nxt;
	} link_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_REQ, ROW_CHK} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		pool_req_t             req;
		pool_reply_t           want;
	} plan_row_t;

	localparam int NPLAN = 35;
	localparam plan_row_t PLAN [NPLAN] = '{
		'{ROW_CHK, '0, '0, '{OP_ALLOC, 1'b0, 4'd0, 10'd0}, '{10'd0, 1'b1, 1'b0, 11'd1023}},
		'{ROW_CHK, '0, '0, '{OP_ALLOC, 1'b1, 4'd15, 10'd1023}, '{10'd1, 1'b1, 1'b0, 11'd1022}},
		'{ROW_CHK, '0, '0, '{OP_FREE, 1'b1, 4'd15, 10'd0}, '{10'd0, 1'b0, 1'b1, 11'd1022}},
		'{ROW_CHK, '0, '0, '{OP_ALLOC, 1'b1, 4'd15, 10'd0}, '{10'd0, 1'b1, 1'b1, 11'd1022}},
		'{ROW_CHK, '0, '0, '{OP_FREE, 1'b0, 4'd15, 10'd1023}, '{10'd0, 1'b0, 1'b0, 11'd1023}},
		'{ROW_CHK, '0, '0, '{OP_ALLOC, 1'b0, 4'd0, 10'd0}, '{10'd1023, 1'b1, 1'b0, 11'd1022}},
		'{ROW_REQ, '0, '0, '{OP_FREE, 1'b1, 4'd0, 10'd1}, '0},
		'{ROW_REQ, '0, '0, '{OP_FREE, 1'b1, 4'd0, 10'd0}, '0},
		'{ROW_REQ, '0, '0, '{OP_ALLOC, 1'b1, 4'd0, 10'd0}, '0},
		'{ROW_REQ, '0, '0, '{OP_ALLOC, 1'b1, 4'd0, 10'd0}, '0},
		'{ROW_REQ, '0, '0, '{OP_ALLOC, 1'b1, 4'd0, 10'd0}, '0},
		'{ROW_CFG, REG_BUFFERS, 11'd1, '0, '0},
		'{ROW_CHK, '0, '0, '{OP_ALLOC, 1'b0, 4'd0, 10'd0}, '{10'd0, 1'b1, 1'b0, 11'd0}},
		'{ROW_CHK, '0, '0, '{OP_ALLOC, 1'b1, 4'd3, 10'd0}, '{10'd0, 1'b0, 1'b0, 11'd0}},
		'{ROW_CHK, '0, '0, '{OP_FREE, 1'b1, 4'd3, 10'd1}, '{10'd0, 1'b0, 1'b0, 11'd0}},
		'{ROW_CHK, '0, '0, '{OP_FREE, 1'b0, 4'd0, 10'd0}, '{10'd0, 1'b0, 1'b0, 11'd1}},
		'{ROW_CHK, '0, '0, '{OP_FREE, 1'b0, 4'd0, 10'd0}, '{10'd0, 1'b0, 1'b0, 11'd1}},
		'{ROW_CFG, REG_BUFFERS, 11'd0, '0, '0},
		'{ROW_CHK, '0, '0, '{OP_ALLOC, 1'b0, 4'd0, 10'd0}, '{10'd0, 1'b0, 1'b0, 11'd0}},
		'{ROW_CHK, '0, '0, '{OP_FREE, 1'b1, 4'd0, 10'd0}, '{10'd0, 1'b0, 1'b0, 11'd0}},
		'{ROW_CFG, REG_BUFFERS, 11'd2047, '0, '0},
		'{ROW_CFG, REG_CACHES, 11'd0, '0, '0},
		'{ROW_CHK, '0, '0, '{OP_FREE, 1'b1, 4'd0, 10'd5}, '{10'd0, 1'b0, 1'b0, 11'd1024}},
		'{ROW_CHK, '0, '0, '{OP_ALLOC, 1'b1, 4'd0, 10'd0}, '{10'd5, 1'b1, 1'b0, 11'd1023}},
		'{ROW_CFG, REG_CACHES, 11'd31, '0, '0},
		'{ROW_CFG, REG_LIMIT, 11'd0, '0, '0},
		'{ROW_CHK, '0, '0, '{OP_FREE, 1'b1, 4'd15, 10'd1023}, '{10'd0, 1'b0, 1'b0, 11'd1024}},
		'{ROW_CFG, REG_LIMIT, 11'd2047, '0, '0},
		'{ROW_CFG, REG_CACHES, 11'd1, '0, '0},
		'{ROW_CHK, '0, '0, '{OP_FREE, 1'b1, 4'd1, 10'd512}, '{10'd0, 1'b0, 1'b0, 11'd1024}},
		'{ROW_CHK, '0, '0, '{OP_FREE, 1'b1, 4'd0, 10'd512}, '{10'd0, 1'b0, 1'b1, 11'd1024}},
		'{ROW_CHK, '0, '0, '{OP_ALLOC, 1'b1, 4'd0, 10'd0}, '{10'd512, 1'b1, 1'b1, 11'd1024}},
		'{ROW_CHK, '0, '0, '{OP_ALLOC, 1'b1, 4'd1, 10'd0}, '{10'd512, 1'b1, 1'b0, 11'd1023}},
		'{ROW_CFG, REG_SPARE, 11'd2047, '0, '0},
		'{ROW_CHK, '0, '0, '{OP_ALLOC, 1'b1, 4'd0, 10'd0}, '{10'd0, 1'b1, 1'b0, 11'd1022}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic op = OP_ALLOC;
	logic cache_valid = 1'b0;
	logic [SEL_W-1:0] cache_sel = '0;
	logic [BUF_IO_W-1:0] buffer_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [BUF_IO_W-1:0] buffer_out;
	logic granted;
	logic from_cache;
	logic [CNT_W-1:0] shared_free;

	logic steady = 1'b0;
	int unsigned cycles = 0;
	int unsigned errors = 0;
	pool_reply_t replies_due [$];
	logic [BUF_IO_W-1:0] held [$];

	logic [NCACHE_W-1:0] cfg_caches;
	logic [CNT_W-1:0] cfg_limit;
	logic [CNT_W-1:0] cfg_bufs;
	link_t link_ram [NUM_BUFFERS_DEF];
	logic [BUF_IO_W-1:0] lst_head [CACHE_SLOTS_DEF];
	logic lst_head_ok [CACHE_SLOTS_DEF];
	logic [CNT_W-1:0] lst_count [CACHE_SLOTS_DEF];
	logic [BUF_IO_W-1:0] pool_head;
	logic pool_head_ok;
	logic [CNT_W-1:0] pool_total;
	logic [CNT_W-1:0] fresh_next;

	per_cache_buffer_free_list_pool_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.cache_valid(cache_valid),
		.cache_sel(cache_sel),
		.buffer_in(buffer_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.buffer_out(buffer_out),
		.granted(granted),
		.from_cache(from_cache),
		.shared_free(shared_free)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [NCACHE_W-1:0] usable_caches();
		return (cfg_caches > CACHE_SLOTS_DEF) ? CACHE_SLOTS_DEF[NCACHE_W-1:0] : cfg_caches;
	endfunction

	function automatic logic [CNT_W-1:0] usable_buffers();
		return (cfg_bufs > NUM_BUFFERS_DEF) ? NUM_BUFFERS_DEF[CNT_W-1:0] : cfg_bufs;
	endfunction

	function automatic void clear_pool();
		for (int i = 0; i < NUM_BUFFERS_DEF; i++) begin
			link_ram[i] = '0;
		end
		for (int i = 0; i < CACHE_SLOTS_DEF; i++) begin
			lst_head[i] = '0;
			lst_head_ok[i] = 1'b0;
			lst_count[i] = '0;
		end
		pool_head = '0;
		pool_head_ok = 1'b0;
		pool_total = usable_buffers();
		fresh_next = '0;
		held.delete();
	endfunction

	function automatic void program_register(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] val);
		case (idx)
		REG_CACHES: cfg_caches = val[NCACHE_W-1:0];
		REG_LIMIT: cfg_limit = val;
		REG_BUFFERS: cfg_bufs = val;
		default: return;
		endcase
		clear_pool();
	endfunction

	function automatic pool_reply_t serve_request(pool_req_t r);
		pool_reply_t rep;
		logic hit;
		link_t l;
		rep = '0;
		hit = r.named && (r.sel < usable_caches());
		if (r.op == OP_ALLOC) begin
			if (hit && lst_head_ok[r.sel] && lst_count[r.sel] != 0) begin
				l = link_ram[lst_head[r.sel]];
				rep.buf_idx = lst_head[r.sel];
				lst_head[r.sel] = l.nxt;
				lst_count[r.sel] = lst_count[r.sel] - 1'b1;
				lst_head_ok[r.sel] = !l.last && lst_count[r.sel] != 0;
				rep.gnt = 1'b1;
				rep.cached = 1'b1;
			end else if (pool_head_ok) begin
				l = link_ram[pool_head];
				rep.buf_idx = pool_head;
				pool_head = l.nxt;
				pool_head_ok = !l.last;
				rep.gnt = 1'b1;
			end else if (fresh_next < usable_buffers()) begin
				rep.buf_idx = fresh_next[BUF_IO_W-1:0];
				fresh_next = fresh_next + 1'b1;
				rep.gnt = 1'b1;
			end
			if (rep.gnt && !rep.cached && pool_total != 0)
				pool_total = pool_total - 1'b1;
		end else if (r.buf_idx < usable_buffers()) begin
			if (hit && lst_count[r.sel] < cfg_limit) begin
				link_ram[r.buf_idx] = lst_head_ok[r.sel] ? link_t'{1'b0, lst_head[r.sel]}
					: link_t'{1'b1, '0};
				lst_head[r.sel] = r.buf_idx;
				lst_head_ok[r.sel] = 1'b1;
				lst_count[r.sel] = lst_count[r.sel] + 1'b1;
				rep.cached = 1'b1;
			end else begin
				link_ram[r.buf_idx] = pool_head_ok ? link_t'{1'b0, pool_head}
					: link_t'{1'b1, '0};
				pool_head = r.buf_idx;
				pool_head_ok = 1'b1;
				if (pool_total < usable_buffers())
					pool_total = pool_total + 1'b1;
			end
		end
		rep.pool_free = pool_total;
		return rep;
	endfunction

	task automatic send_request(pool_req_t r, logic typed, pool_reply_t want);
		pool_reply_t predicted;
		in_valid <= 1'b1;
		op <= r.op;
		cache_valid <= r.named;
		cache_sel <= r.sel;
		buffer_in <= r.buf_idx;
		do @(posedge clk); while (!in_ready);
		predicted = serve_request(r);
		if (r.op == OP_ALLOC && predicted.gnt)
			held.push_back(predicted.buf_idx);
		replies_due.push_back(typed ? want : predicted);
		if (!steady && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 36);
		end
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		in_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		program_register(idx, val);
	endtask

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 36);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("[per_cache_buffer_free_list_pool_unit] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin : check_replies
		pool_reply_t got;
		pool_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{buffer_out, granted, from_cache, shared_free};
			if (replies_due.size() == 0) begin
				if (errors < 10)
					$display("unexpected result: buffer_out %0d granted %0d from_cache %0d shared_free %0d",
						got.buf_idx, got.gnt, got.cached, got.pool_free);
				errors++;
			end else begin
				want = replies_due.pop_front();
				if (got !== want) begin
					if (errors < 10)
						$display({"mismatch (exp/got): buffer_out %0d/%0d granted %0d/%0d ",
							"from_cache %0d/%0d shared_free %0d/%0d"},
							want.buf_idx, got.buf_idx, want.gnt, got.gnt,
							want.cached, got.cached, want.pool_free, got.pool_free);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		pool_req_t r;
		logic [NCACHE_W-1:0] ncu;
		logic [CFG_DATA_W-1:0] set_caches;
		logic [CFG_DATA_W-1:0] set_limit;
		logic [CFG_DATA_W-1:0] set_bufs;
		int unsigned pick;
		int unsigned roll;

		cfg_caches = 5'd16;
		cfg_limit = 11'd32;
		cfg_bufs = 11'd1024;
		clear_pool();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NPLAN; i++) begin
			if (PLAN[i].kind == ROW_CFG)
				write_register(PLAN[i].reg_idx, PLAN[i].reg_val);
			else
				send_request(PLAN[i].req, PLAN[i].kind == ROW_CHK, PLAN[i].want);
		end

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
			0: begin set_caches = 11'd16; set_limit = 11'd32; set_bufs = 11'd1024; end
			1: begin set_caches = 11'd4; set_limit = 11'd2; set_bufs = 11'd24; end
			2: begin set_caches = 11'd1; set_limit = 11'd1024; set_bufs = 11'd16; end
			3: begin set_caches = 11'd16; set_limit = 11'd0; set_bufs = 11'd8; end
			4: begin set_caches = 11'd31; set_limit = 11'd2047; set_bufs = 11'd2047; end
			default: begin
				set_caches = CFG_DATA_W'($urandom_range(1, 16));
				set_limit = CFG_DATA_W'($urandom_range(0, 8));
				set_bufs = CFG_DATA_W'($urandom_range(2, 64));
			end
			endcase
			write_register(REG_CACHES, set_caches);
			write_register(REG_LIMIT, set_limit);
			write_register(REG_BUFFERS, set_bufs);
			steady = (ph == 2);
			ncu = usable_caches();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(99);
				r.buf_idx = BUF_IO_W'($urandom_range(1023));
				r.named = ($urandom_range(99) < 80);
				r.sel = (ncu != 0 && $urandom_range(99) < 85) ? SEL_W'($urandom_range(ncu - 1))
					: SEL_W'($urandom_range(15));
				if (roll < 15) begin
					r.op = 1'($urandom_range(1));
				end else if (held.size() != 0 && $urandom_range(1) == 1) begin
					r.op = OP_FREE;
					pick = $urandom_range(held.size() - 1);
					r.buf_idx = held[pick];
					held.delete(pick);
				end else begin
					r.op = OP_ALLOC;
				end
				send_request(r, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		steady = 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (errors == 0)
			$display("[per_cache_buffer_free_list_pool_unit] OK");
		else
			$display("[per_cache_buffer_free_list_pool_unit] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
